### design/pdf_pkg.sv
// Shared types and constants for the pipeline decode and forwarding block.
package pdf_pkg;

    // Instruction codes
    typedef enum logic [3:0] {
        OP_HALT  = 4'd0,
        OP_NOP   = 4'd1,
        OP_RRMOV = 4'd2,
        OP_IRMOV = 4'd3,
        OP_RMMOV = 4'd4,
        OP_MRMOV = 4'd5,
        OP_ALU   = 4'd6,
        OP_JUMP  = 4'd7,
        OP_CALL  = 4'd8,
        OP_RET   = 4'd9,
        OP_PUSH  = 4'd10,
        OP_POP   = 4'd11
    } t_icode;

    localparam logic [3:0]  REG_SP       = 4'd4;
    localparam logic [3:0]  REG_NONE     = 4'd15;
    // Value seen for a source that lies outside the register file
    localparam logic [31:0] VAL_OUT_OF_FILE = 32'h0000_000f;

    // Register selection for one instruction
    typedef struct packed {
        logic [3:0] src_a;
        logic [3:0] src_b;
        logic [3:0] dst_e;
        logic [3:0] dst_m;
        logic       a_from_pc;   // call or jump: operand A is valP
    } t_regsel;

    // Destinations and values of the later stages
    typedef struct packed {
        logic [3:0]  mem_dst_m;
        logic [3:0]  mem_dst_e;
        logic [31:0] mem_val_e;
        logic [3:0]  wb_dst_m;
        logic [31:0] wb_val_m;
        logic [3:0]  wb_dst_e;
        logic [31:0] wb_val_e;
    } t_fwd_src;

    // Register file read, or the out-of-file marker for sources 8 and up
    function automatic logic [31:0] read_or_none(input logic [3:0] src,
                                                 input logic [31:0] file_val);
        return src[3] ? VAL_OUT_OF_FILE : file_val;
    endfunction

endpackage

### design/pdf_regsel.sv
// Source and destination register selection per instruction code.
module pdf_regsel (
    input  logic [3:0]       i_icode,
    input  logic [7:0]       i_reg_specifier,
    output pdf_pkg::t_regsel o_sel
);
    import pdf_pkg::*;

    logic [3:0] ra;
    logic [3:0] rb;

    assign ra = i_reg_specifier[7:4];
    assign rb = i_reg_specifier[3:0];

    // Decode the opcode into register roles
    always_comb begin
        o_sel.src_a     = REG_NONE;
        o_sel.src_b     = REG_NONE;
        o_sel.dst_e     = REG_NONE;
        o_sel.dst_m     = REG_NONE;
        o_sel.a_from_pc = 1'b0;
        unique case (i_icode)
            OP_RRMOV: begin
                o_sel.src_a = ra;
                o_sel.dst_e = rb;
            end
            OP_IRMOV: begin
                o_sel.dst_e = rb;
            end
            OP_RMMOV: begin
                o_sel.src_a = ra;
                o_sel.src_b = rb;
            end
            OP_MRMOV: begin
                o_sel.src_b = rb;
                o_sel.dst_m = ra;
            end
            OP_ALU: begin
                o_sel.src_a = ra;
                o_sel.src_b = rb;
                o_sel.dst_e = rb;
            end
            OP_JUMP: begin
                o_sel.a_from_pc = 1'b1;
            end
            OP_CALL: begin
                o_sel.src_b     = REG_SP;
                o_sel.dst_e     = REG_SP;
                o_sel.a_from_pc = 1'b1;
            end
            OP_RET: begin
                o_sel.src_a = REG_SP;
                o_sel.src_b = REG_SP;
                o_sel.dst_e = REG_SP;
            end
            OP_PUSH: begin
                o_sel.src_a = ra;
                o_sel.src_b = REG_SP;
                o_sel.dst_e = REG_SP;
            end
            OP_POP: begin
                o_sel.src_a = REG_SP;
                o_sel.src_b = REG_SP;
                o_sel.dst_e = REG_SP;
                o_sel.dst_m = ra;
            end
            default: begin
                // halt, nop and undefined codes use no registers
            end
        endcase
    end

endmodule

### design/pdf_fwd.sv
// Priority forwarding mux for one operand.
module pdf_fwd (
    input  logic [3:0]        i_src,
    input  logic [31:0]       i_file_val,
    input  pdf_pkg::t_fwd_src i_fwd,
    output logic [31:0]       o_val,
    output logic              o_pending
);
    import pdf_pkg::*;

    // Pick the newest producer; a pending load wins and gives no value yet
    always_comb begin
        o_pending = 1'b0;
        priority if (i_src == i_fwd.mem_dst_m) begin
            o_pending = 1'b1;
            o_val     = '0;
        end else if (i_src == i_fwd.mem_dst_e) begin
            o_val = i_fwd.mem_val_e;
        end else if (i_src == i_fwd.wb_dst_m) begin
            o_val = i_fwd.wb_val_m;
        end else if (i_src == i_fwd.wb_dst_e) begin
            o_val = i_fwd.wb_val_e;
        end else begin
            o_val = read_or_none(i_src, i_file_val);
        end
    end

endmodule

### design/pipeline_decode_forwarding.sv
// Top level of the pipeline decode stage with operand forwarding.
//
// Each request is captured in an input register, decoded and forwarded by
// short combinational logic, and held in an output register until taken.
// A request passes the input register, then the result register, and one
// request is accepted every cycle while the output side does not stall;
// the two registers let a new request enter while a finished result waits.
module pipeline_decode_forwarding (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // request channel
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [3:0]  i_icode,
    input  logic [7:0]  i_reg_specifier,
    input  logic [31:0] i_next_pc,
    input  logic [3:0]  i_mem_dst_m,
    input  logic [3:0]  i_mem_dst_e,
    input  logic [31:0] i_mem_val_e,
    input  logic [3:0]  i_wb_dst_m,
    input  logic [31:0] i_wb_val_m,
    input  logic [3:0]  i_wb_dst_e,
    input  logic [31:0] i_wb_val_e,
    input  logic [31:0] i_reg_read_a,
    input  logic [31:0] i_reg_read_b,
    // result channel
    output logic        o_valid,
    input  logic        i_stall,
    output logic [3:0]  o_src_a,
    output logic [3:0]  o_src_b,
    output logic [3:0]  o_dst_e,
    output logic [3:0]  o_dst_m,
    output logic [31:0] o_val_a,
    output logic [31:0] o_val_b,
    output logic        o_a_from_execute,
    output logic        o_a_from_memory,
    output logic        o_b_from_execute,
    output logic        o_b_from_memory
);
    import pdf_pkg::*;

    // input register
    logic        r_in_valid;
    logic [3:0]  r_icode;
    logic [7:0]  r_reg_specifier;
    logic [31:0] r_next_pc;
    t_fwd_src    r_fwd;
    logic [31:0] r_reg_read_a;
    logic [31:0] r_reg_read_b;

    // result register
    logic        r_out_valid;
    logic [3:0]  r_src_a;
    logic [3:0]  r_src_b;
    logic [3:0]  r_dst_e;
    logic [3:0]  r_dst_m;
    logic [31:0] r_val_a;
    logic [31:0] r_val_b;
    logic        r_a_from_execute;
    logic        r_a_from_memory;
    logic        r_b_from_memory;

    logic        out_advance;
    logic        in_advance;
    t_regsel     sel;
    logic [31:0] fwd_val_a;
    logic        fwd_pend_a;
    logic [31:0] fwd_val_b;
    logic        fwd_pend_b;
    logic        n_out_valid;
    logic        n_in_valid;

    // Advance each stage when the one after it can take its contents
    assign out_advance = !r_out_valid || !i_stall;
    assign in_advance  = !r_in_valid || out_advance;
    assign o_stall     = !in_advance;

    assign n_in_valid  = in_advance ? i_valid : r_in_valid;
    assign n_out_valid = out_advance ? r_in_valid : r_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_in_valid  <= n_in_valid;
            r_out_valid <= n_out_valid;
        end
    end

    // Capture the request
    always_ff @(posedge i_clk) begin
        if (in_advance && i_valid) begin
            r_icode         <= i_icode;
            r_reg_specifier <= i_reg_specifier;
            r_next_pc       <= i_next_pc;
            r_fwd.mem_dst_m <= i_mem_dst_m;
            r_fwd.mem_dst_e <= i_mem_dst_e;
            r_fwd.mem_val_e <= i_mem_val_e;
            r_fwd.wb_dst_m  <= i_wb_dst_m;
            r_fwd.wb_val_m  <= i_wb_val_m;
            r_fwd.wb_dst_e  <= i_wb_dst_e;
            r_fwd.wb_val_e  <= i_wb_val_e;
            r_reg_read_a    <= i_reg_read_a;
            r_reg_read_b    <= i_reg_read_b;
        end
    end

    pdf_regsel u_regsel (
        .i_icode         (r_icode),
        .i_reg_specifier (r_reg_specifier),
        .o_sel           (sel)
    );

    pdf_fwd u_fwd_a (
        .i_src      (sel.src_a),
        .i_file_val (r_reg_read_a),
        .i_fwd      (r_fwd),
        .o_val      (fwd_val_a),
        .o_pending  (fwd_pend_a)
    );

    pdf_fwd u_fwd_b (
        .i_src      (sel.src_b),
        .i_file_val (r_reg_read_b),
        .i_fwd      (r_fwd),
        .o_val      (fwd_val_b),
        .o_pending  (fwd_pend_b)
    );

    // Load the result; call and jump pass valP as operand A
    always_ff @(posedge i_clk) begin
        if (out_advance && r_in_valid) begin
            r_src_a          <= sel.src_a;
            r_src_b          <= sel.src_b;
            r_dst_e          <= sel.dst_e;
            r_dst_m          <= sel.dst_m;
            r_val_a          <= sel.a_from_pc ? r_next_pc : fwd_val_a;
            r_val_b          <= fwd_val_b;
            r_a_from_execute <= !sel.a_from_pc;
            r_a_from_memory  <= !sel.a_from_pc && fwd_pend_a;
            r_b_from_memory  <= fwd_pend_b;
        end
    end

    assign o_valid          = r_out_valid;
    assign o_src_a          = r_src_a;
    assign o_src_b          = r_src_b;
    assign o_dst_e          = r_dst_e;
    assign o_dst_m          = r_dst_m;
    assign o_val_a          = r_val_a;
    assign o_val_b          = r_val_b;
    assign o_a_from_execute = r_a_from_execute;
    assign o_a_from_memory  = r_a_from_memory;
    assign o_b_from_execute = 1'b1;
    assign o_b_from_memory  = r_b_from_memory;

    // A call or jump never waits on a load for operand A
    a_pc_no_pending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_a_from_execute |-> !o_a_from_memory)
        else $error("operand A pending on call or jump");

    // A pending load gives a zero operand
    b_pending_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_b_from_memory |-> o_val_b == 32'd0)
        else $error("operand B pending with nonzero value");

    // An accepted request occupies the input register next cycle
    in_capture: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_stall |=> r_in_valid)
        else $error("accepted request lost");

    // A filled input register moves into the result when the output frees
    out_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_valid && !(o_valid && i_stall) |=> o_valid)
        else $error("result register not loaded");

endmodule
